// ----- sv/eolc_pkg.sv -----
// ----------------------------------------------------------------------------
// eolc_pkg
// shared types and constants of the encoder offset and linearization block
// ----------------------------------------------------------------------------
package eolc_pkg;

  localparam int CMD_W    = 2;
  localparam int ANGLE_W  = 20;
  localparam int RAW_W    = 16;
  localparam int TAB_AW   = 7;
  localparam int TAB_SIZE = 128;
  localparam int STAT_W   = 2;
  localparam int TVAL_W   = 16;
  localparam int ELEC_W   = 17;
  localparam int SCNT_W   = 12;
  localparam int CPR_W    = 17;
  localparam int PAIR_W   = ANGLE_W + 1;

  localparam logic [CPR_W-1:0] CPR_RESET = 17'd16384;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_FWD = 2'd0,
    CMD_LOAD_BWD = 2'd1,
    CMD_COMPUTE  = 2'd2,
    CMD_READ     = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DONE     = 2'd1,
    ST_READ     = 2'd2,
    ST_REJECTED = 2'd3
  } status_t;

endpackage

// ----- sv/eolc_ram.sv -----
// ----------------------------------------------------------------------------
// eolc_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module eolc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/encoder_offset_linearization_calc.sv -----
// ----------------------------------------------------------------------------
// encoder_offset_linearization_calc
// collects forward and backward position error samples, derives the
// electrical offset and a rotated 128-entry eccentricity correction table
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  in       | in_valid / in_stall   | command, error_angle, raw_position, table_index
//  out      | out_valid / out_stall | status, table_value, elec_offset, sample_count
//  cfg      | cfg_wr_en             | cfg_wr_data (counts_per_rev)
//
//  loads are answered straight from idle, table reads through a wait state
//  for the registered ram read; compute makes one pass over the sample rams
//  for the sum, then per table entry a window pass over the same rams, the
//  scaling multiplies, a clamp and a reciprocal multiply
//  rst is synchronous; it clears counts, offset and table valid bits
//  the sample rams are not cleared; compute only runs with both stores full
//  in_stall is high while a command is in work or the result is held
// ----------------------------------------------------------------------------
module encoder_offset_linearization_calc #(
  parameter int POLE_PAIRS = 21,
  parameter int WINDOW     = 128
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [eolc_pkg::CPR_W-1:0]       cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [eolc_pkg::CMD_W-1:0]       command,
  input  logic signed [eolc_pkg::ANGLE_W-1:0] error_angle,
  input  logic [eolc_pkg::RAW_W-1:0]       raw_position,
  input  logic [eolc_pkg::TAB_AW-1:0]      table_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [eolc_pkg::STAT_W-1:0]      status,
  output logic signed [eolc_pkg::TVAL_W-1:0] table_value,
  output logic signed [eolc_pkg::ELEC_W-1:0] elec_offset,
  output logic [eolc_pkg::SCNT_W-1:0]      sample_count
);

  import eolc_pkg::*;

  // sizes
  localparam int NSAMP  = 128 * POLE_PAIRS;
  localparam int ADDR_W = $clog2(NSAMP);
  localparam int CNT_W  = $clog2(NSAMP + 1);
  localparam int WIN_W  = $clog2(WINDOW);
  localparam int S_W    = 22 + ADDR_W;
  localparam int D_W    = 22 + WIN_W;
  localparam int DN_W   = D_W + CNT_W;
  localparam int SW_W   = S_W + WIN_W + 2;
  localparam int P_W    = ((DN_W > SW_W) ? DN_W : SW_W) + 1;
  localparam int NUM_W  = P_W + CPR_W;
  localparam int T_W    = ADDR_W + 2;

  // divide by 2*WINDOW*NSAMP*65536 = (WINDOW*POLE_PAIRS) << 24:
  // shift by 24, clamp just above the saturation point, then multiply by
  // the rounded-up reciprocal of WINDOW*POLE_PAIRS (exact for the clamped range)
  localparam int     DIV_SH = 24;
  localparam int     DIVC   = WINDOW * POLE_PAIRS;
  localparam longint XMAX   = longint'(32769) * DIVC;
  localparam int     XS_W   = NUM_W - DIV_SH;
  localparam int     XC_W   = $clog2(XMAX + 1);
  localparam int     RSH    = XC_W + $clog2(DIVC);
  localparam longint RM     = ((longint'(1) << RSH) + DIVC - 1) / DIVC;
  localparam int     RM_W   = XC_W + 1;
  localparam int     PR_W   = XC_W + RM_W;
  localparam logic [RM_W-1:0] RM_C = RM_W'(RM);

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_SUM, S_SUM_DRAIN, S_WIN_START, S_WIN, S_WIN_DRAIN,
    S_MUL_A, S_MUL_B, S_MUL_C, S_DIV, S_RECIP, S_WRITE, S_DONE
  } state_t;

  state_t state;

  // control and architectural state
  logic [CNT_W-1:0]         fcount;
  logic [CNT_W-1:0]         bcount;
  logic [RAW_W-1:0]         raw_first;
  logic [RAW_W-1:0]         raw_last;
  logic signed [ELEC_W-1:0] offset_result;
  logic [CPR_W-1:0]         counts_per_rev;
  logic [TAB_SIZE-1:0]      tvalid;
  logic [TAB_AW-1:0]        rd_ix;

  // compute sequencer
  logic [ADDR_W-1:0]        idx;
  logic [WIN_W-1:0]         jcnt;
  logic                     rd_valid;
  logic signed [S_W-1:0]    s_acc;
  logic signed [D_W-1:0]    d_acc;
  logic [ADDR_W-1:0]        centre;
  logic [TAB_AW-1:0]        k;
  logic signed [P_W-1:0]    dn;
  logic signed [P_W-1:0]    sw;
  logic                     neg;
  logic [P_W-1:0]           mag;
  logic [NUM_W-1:0]         qreg;
  logic [XC_W-1:0]          xc;

  // ram ports
  logic                     f_we;
  logic                     b_we;
  logic [ADDR_W-1:0]        b_raddr;
  logic [ANGLE_W-1:0]       f_rdata;
  logic [ANGLE_W-1:0]       b_rdata;
  logic                     t_we;
  logic [TAB_AW-1:0]        t_waddr;
  logic [TVAL_W-1:0]        t_rdata;

  // datapath helpers
  logic                     in_fire;
  logic                     out_free;
  logic signed [PAIR_W-1:0] pair;
  logic [S_W-1:0]           s_mag;
  logic [15:0]              s_low;
  logic signed [ELEC_W-1:0] offset_c;
  logic [T_W-1:0]           start_t;
  logic [ADDR_W-1:0]        start_idx;
  logic [ADDR_W-1:0]        idx_inc;
  logic signed [P_W-1:0]    d_ext;
  logic signed [P_W-1:0]    s_ext;
  logic signed [P_W-1:0]    diff;
  logic [XS_W-1:0]          xs;
  logic [PR_W-1:0]          prod;
  logic signed [TVAL_W-1:0] sat_val;
  logic [RAW_W:0]           raw_sum;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE) || !out_free;
  assign in_fire  = in_valid && !in_stall;

  // sample writes go straight to the rams on the accepting edge
  assign f_we = in_fire && (command == CMD_LOAD_FWD) && (fcount < CNT_W'(NSAMP));
  assign b_we = in_fire && (command == CMD_LOAD_BWD) && (bcount < CNT_W'(NSAMP));
  assign b_raddr = ADDR_W'(NSAMP - 1) - idx;

  eolc_ram #(.WIDTH(ANGLE_W), .DEPTH(NSAMP)) u_fwd_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (fcount[ADDR_W-1:0]),
    .wdata (error_angle),
    .raddr (idx),
    .rdata (f_rdata)
  );

  eolc_ram #(.WIDTH(ANGLE_W), .DEPTH(NSAMP)) u_bwd_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (bcount[ADDR_W-1:0]),
    .wdata (error_angle),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  // table rotation from the mean raw count of first and last sample
  assign raw_sum = {1'b0, raw_first} + {1'b0, raw_last};
  assign t_we    = (state == S_WRITE);
  assign t_waddr = raw_sum[TAB_AW+7:8] + k;

  eolc_ram #(.WIDTH(TVAL_W), .DEPTH(TAB_SIZE)) u_tab_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (sat_val),
    .raddr (table_index),
    .rdata (t_rdata)
  );

  // forward sample i plus backward sample NSAMP-1-i
  assign pair = {f_rdata[ANGLE_W-1], f_rdata} + {b_rdata[ANGLE_W-1], b_rdata};

  // offset = trunc(S/256) rem 65536, sign of S kept
  assign s_mag    = s_acc[S_W-1] ? S_W'(-s_acc) : S_W'(s_acc);
  assign s_low    = s_mag[23:8];
  assign offset_c = s_acc[S_W-1] ? -ELEC_W'({1'b0, s_low}) : ELEC_W'({1'b0, s_low});

  // window start (centre - WINDOW/2) mod NSAMP, input below 3*NSAMP
  assign start_t = T_W'(centre) + T_W'(2 * NSAMP - WINDOW / 2);
  always_comb begin
    if (start_t >= T_W'(2 * NSAMP)) begin
      start_idx = ADDR_W'(start_t - T_W'(2 * NSAMP));
    end else if (start_t >= T_W'(NSAMP)) begin
      start_idx = ADDR_W'(start_t - T_W'(NSAMP));
    end else begin
      start_idx = ADDR_W'(start_t);
    end
  end
  assign idx_inc = (idx == ADDR_W'(NSAMP - 1)) ? '0 : idx + 1'b1;

  // (D*NSAMP - S*WINDOW) terms
  assign d_ext = P_W'(d_acc);
  assign s_ext = P_W'(s_acc);
  assign diff  = dn - sw;

  // scaled magnitude after the power of two part of the divisor
  assign xs   = qreg[NUM_W-1:DIV_SH];
  assign prod = PR_W'(xc) * PR_W'(RM_C);

  // saturate the signed quotient to 16 bits
  always_comb begin
    if (!neg) begin
      if (qreg > NUM_W'(32767)) begin
        sat_val = 16'sh7fff;
      end else begin
        sat_val = TVAL_W'(qreg);
      end
    end else begin
      if (qreg > NUM_W'(32768)) begin
        sat_val = -16'sh8000;
      end else begin
        sat_val = -TVAL_W'(qreg);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      counts_per_rev <= CPR_RESET;
    end else if (cfg_wr_en) begin
      counts_per_rev <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fcount        <= '0;
      bcount        <= '0;
      raw_first     <= '0;
      raw_last      <= '0;
      offset_result <= '0;
      tvalid        <= '0;
      rd_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            table_value  <= '0;
            elec_offset  <= offset_result;
            sample_count <= '0;
            out_valid    <= 1'b1;
            case (cmd_t'(command))
              CMD_LOAD_FWD: begin
                if (f_we) begin
                  if (fcount == '0) begin
                    raw_first <= raw_position;
                  end
                  fcount       <= fcount + 1'b1;
                  sample_count <= SCNT_W'(fcount + 1'b1);
                  status       <= ST_ACCEPTED;
                end else begin
                  sample_count <= SCNT_W'(fcount);
                  status       <= ST_REJECTED;
                end
              end
              CMD_LOAD_BWD: begin
                if (b_we) begin
                  if (bcount == CNT_W'(NSAMP - 1)) begin
                    raw_last <= raw_position;
                  end
                  bcount       <= bcount + 1'b1;
                  sample_count <= SCNT_W'(bcount + 1'b1);
                  status       <= ST_ACCEPTED;
                end else begin
                  sample_count <= SCNT_W'(bcount);
                  status       <= ST_REJECTED;
                end
              end
              CMD_COMPUTE: begin
                if (fcount == CNT_W'(NSAMP) && bcount == CNT_W'(NSAMP)) begin
                  out_valid <= 1'b0;
                  idx       <= '0;
                  s_acc     <= '0;
                  state     <= S_SUM;
                end else begin
                  status <= ST_REJECTED;
                end
              end
              CMD_READ: begin
                out_valid <= 1'b0;
                rd_ix     <= table_index;
                state     <= S_RD_WAIT;
              end
              default: begin
                status <= ST_REJECTED;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          status       <= ST_READ;
          table_value  <= tvalid[rd_ix] ? t_rdata : '0;
          elec_offset  <= offset_result;
          sample_count <= '0;
          out_valid    <= 1'b1;
          state        <= S_IDLE;
        end
        S_SUM: begin
          rd_valid <= 1'b1;
          if (rd_valid) begin
            s_acc <= s_acc + S_W'(pair);
          end
          idx <= idx + 1'b1;
          if (idx == ADDR_W'(NSAMP - 1)) begin
            state <= S_SUM_DRAIN;
          end
        end
        S_SUM_DRAIN: begin
          s_acc    <= s_acc + S_W'(pair);
          rd_valid <= 1'b0;
          centre   <= '0;
          k        <= '0;
          state    <= S_WIN_START;
        end
        S_WIN_START: begin
          offset_result <= offset_c;
          idx           <= start_idx;
          jcnt          <= '0;
          d_acc         <= '0;
          state         <= S_WIN;
        end
        S_WIN: begin
          rd_valid <= 1'b1;
          if (rd_valid) begin
            d_acc <= d_acc + D_W'(pair);
          end
          idx  <= idx_inc;
          jcnt <= jcnt + 1'b1;
          if (jcnt == WIN_W'(WINDOW - 1)) begin
            state <= S_WIN_DRAIN;
          end
        end
        S_WIN_DRAIN: begin
          d_acc    <= d_acc + D_W'(pair);
          rd_valid <= 1'b0;
          state    <= S_MUL_A;
        end
        S_MUL_A: begin
          dn    <= d_ext * $signed(P_W'(NSAMP));
          sw    <= s_ext * $signed(P_W'(WINDOW));
          state <= S_MUL_B;
        end
        S_MUL_B: begin
          neg   <= diff[P_W-1];
          mag   <= diff[P_W-1] ? P_W'(-diff) : P_W'(diff);
          state <= S_MUL_C;
        end
        S_MUL_C: begin
          qreg  <= NUM_W'(mag) * NUM_W'(counts_per_rev);
          state <= S_DIV;
        end
        S_DIV: begin
          // anything at or above the clamp saturates either way
          xc    <= (xs > XS_W'(XMAX)) ? XC_W'(XMAX) : XC_W'(xs);
          state <= S_RECIP;
        end
        S_RECIP: begin
          qreg  <= NUM_W'(prod >> RSH);
          state <= S_WRITE;
        end
        S_WRITE: begin
          tvalid[t_waddr] <= 1'b1;
          k               <= k + 1'b1;
          centre          <= centre + ADDR_W'(POLE_PAIRS);
          if (k == TAB_AW'(TAB_SIZE - 1)) begin
            state <= S_DONE;
          end else begin
            state <= S_WIN_START;
          end
        end
        S_DONE: begin
          status       <= ST_DONE;
          table_value  <= '0;
          elec_offset  <= offset_result;
          sample_count <= '0;
          out_valid    <= 1'b1;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sv/eolc_checker.sv -----
// ----------------------------------------------------------------------------
// eolc_checker
// port level checks of the encoder offset and linearization block
// ----------------------------------------------------------------------------
module eolc_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             cfg_wr_en,
  input logic [eolc_pkg::CPR_W-1:0]       cfg_wr_data,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [eolc_pkg::CMD_W-1:0]       command,
  input logic signed [eolc_pkg::ANGLE_W-1:0] error_angle,
  input logic [eolc_pkg::RAW_W-1:0]       raw_position,
  input logic [eolc_pkg::TAB_AW-1:0]      table_index,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [eolc_pkg::STAT_W-1:0]      status,
  input logic signed [eolc_pkg::TVAL_W-1:0] table_value,
  input logic signed [eolc_pkg::ELEC_W-1:0] elec_offset,
  input logic [eolc_pkg::SCNT_W-1:0]      sample_count
);

  import eolc_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(table_value))
    else $error("held result changed");

  // a table read occupies the block for at least the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_READ
    |=> in_stall)
    else $error("input taken during multi-cycle command");

  // only table reads carry a table value
  a_tval: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_READ |-> table_value == '0)
    else $error("table value on non-read result");

  // compute and read results carry no sample count
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DONE || status == ST_READ) |-> sample_count == '0)
    else $error("sample count on compute or read result");

endmodule

bind encoder_offset_linearization_calc eolc_checker u_eolc_checker (.*);
